FILE: rtl/core/adcd_pkg.sv
package adcd_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_STAGES   = 128;
    localparam int DEF_STAGE_DELAY  = 2;
    localparam int DEF_SAMPLE_WIDTH = 24;

    // Fixed field widths of the configuration registers.
    localparam int COUNT_W    = 8;
    localparam int COEF_W     = 16;
    localparam int COEF_FRAC  = 15;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [COUNT_W-1:0]       COUNT_RESET = 8'd1;
    localparam logic signed [COEF_W-1:0] COEF_RESET  = 16'sd16384;

    // Register indexes on the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_STAGE_COUNT   = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FEEDBACK_COEF = 1'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PH_RD,
        ST_RING_RD,
        ST_Y,
        ST_MUL_Y,
        ST_V,
        ST_OUT
    } step_t;

    typedef enum logic [1:0] {
        SEQ_WAIT_IN,
        SEQ_JUMP,
        SEQ_LOOP,
        SEQ_WAIT_OUT
    } seq_op_t;

    typedef enum logic {
        MUL_X,
        MUL_Y
    } mul_src_t;

    // One microcode word.
    typedef struct packed {
        logic     accept;
        logic     mul_en;
        mul_src_t mul_src;
        logic     ph_rd;
        logic     ph_wr;
        logic     ring_rd;
        logic     y_ld;
        logic     ring_wr;
        logic     adv;
        logic     out_ld;
        seq_op_t  seq_op;
        step_t    target;
    } ucode_t;

    // Strobes from the sequencer to the datapath.
    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        mul_src_t mul_src;
        logic     ph_rd;
        logic     ph_wr;
        logic     ring_rd;
        logic     y_ld;
        logic     ring_wr;
        logic     adv;
        logic     out_ld;
    } ctrl_t;

    // Status from the datapath back to the sequencer.
    typedef struct packed {
        logic clr_busy;
        logic last_stage;
        logic out_free;
    } dp_status_t;

    function automatic ucode_t ucode_rom(input step_t s);
        ucode_t w;
        w = '{accept: 1'b0, mul_en: 1'b0, mul_src: MUL_X, ph_rd: 1'b0, ph_wr: 1'b0,
              ring_rd: 1'b0, y_ld: 1'b0, ring_wr: 1'b0, adv: 1'b0, out_ld: 1'b0,
              seq_op: SEQ_JUMP, target: ST_IDLE};
        case (s)
            ST_IDLE:
            begin
                w.accept = 1'b1;
                w.seq_op = SEQ_WAIT_IN;
                w.target = ST_PH_RD;
            end
            ST_PH_RD:
            begin
                w.mul_en  = 1'b1;
                w.mul_src = MUL_X;
                w.ph_rd   = 1'b1;
                w.target  = ST_RING_RD;
            end
            ST_RING_RD:
            begin
                w.ph_wr   = 1'b1;
                w.ring_rd = 1'b1;
                w.target  = ST_Y;
            end
            ST_Y:
            begin
                w.y_ld   = 1'b1;
                w.target = ST_MUL_Y;
            end
            ST_MUL_Y:
            begin
                w.mul_en  = 1'b1;
                w.mul_src = MUL_Y;
                w.target  = ST_V;
            end
            ST_V:
            begin
                w.ring_wr = 1'b1;
                w.adv     = 1'b1;
                w.seq_op  = SEQ_LOOP;
                w.target  = ST_PH_RD;
            end
            ST_OUT:
            begin
                w.out_ld = 1'b1;
                w.seq_op = SEQ_WAIT_OUT;
                w.target = ST_IDLE;
            end
            default:
            begin
                w.seq_op = SEQ_JUMP;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/core/adcd_seq.sv
module adcd_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  adcd_pkg::dp_status_t status,
    output logic                in_ready,
    output adcd_pkg::ctrl_t     ctrl
);

    adcd_pkg::step_t  step_reg;
    adcd_pkg::step_t  step_next;
    adcd_pkg::ucode_t cw;
    logic             in_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= adcd_pkg::ST_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_comb
    begin
        cw       = adcd_pkg::ucode_rom(step_reg);
        in_ready = cw.accept && !status.clr_busy;
        in_fire  = in_ready && in_valid;

        ctrl.load_in = in_fire;
        ctrl.mul_en  = cw.mul_en;
        ctrl.mul_src = cw.mul_src;
        ctrl.ph_rd   = cw.ph_rd;
        ctrl.ph_wr   = cw.ph_wr;
        ctrl.ring_rd = cw.ring_rd;
        ctrl.y_ld    = cw.y_ld;
        ctrl.ring_wr = cw.ring_wr;
        ctrl.adv     = cw.adv;
        ctrl.out_ld  = cw.out_ld && status.out_free;

        step_next = step_reg;
        case (cw.seq_op)
            adcd_pkg::SEQ_WAIT_IN:
            begin
                if (in_fire)
                begin
                    step_next = cw.target;
                end
            end
            adcd_pkg::SEQ_JUMP:
            begin
                step_next = cw.target;
            end
            adcd_pkg::SEQ_LOOP:
            begin
                // Fall through to the next word after the last active stage.
                if (status.last_stage)
                begin
                    step_next = adcd_pkg::step_t'(3'(step_reg) + 3'd1);
                end
                else
                begin
                    step_next = cw.target;
                end
            end
            adcd_pkg::SEQ_WAIT_OUT:
            begin
                if (status.out_free)
                begin
                    step_next = cw.target;
                end
            end
            default:
            begin
                step_next = adcd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/adcd_datapath.sv
module adcd_datapath #(
    parameter int MAX_STAGES   = adcd_pkg::DEF_MAX_STAGES,
    parameter int STAGE_DELAY  = adcd_pkg::DEF_STAGE_DELAY,
    parameter int SAMPLE_WIDTH = adcd_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  adcd_pkg::ctrl_t                       ctrl,
    input  logic [adcd_pkg::COUNT_W-1:0]          stage_count,
    input  logic signed [adcd_pkg::COEF_W-1:0]    coef,
    input  logic signed [SAMPLE_WIDTH-1:0]        sample_in,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output logic signed [SAMPLE_WIDTH-1:0]        sample_out,
    output adcd_pkg::dp_status_t                  status
);

    localparam int RING_SIZE = MAX_STAGES * STAGE_DELAY;
    localparam int RA_W      = (RING_SIZE > 1) ? $clog2(RING_SIZE) : 1;
    localparam int SA_W      = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int PH_W      = (STAGE_DELAY > 1) ? $clog2(STAGE_DELAY) : 1;
    localparam int STW       = SAMPLE_WIDTH + 4;
    localparam int PW        = SAMPLE_WIDTH + adcd_pkg::COEF_W;
    localparam int WW        = PW + 2;
    localparam logic signed [PW:0] ROUND_HALF = (PW+1)'(1 << (adcd_pkg::COEF_FRAC - 1));

    logic signed [STW-1:0]          ring_mem [RING_SIZE];
    logic [PH_W-1:0]                phase_mem [MAX_STAGES];

    logic                           clr_busy_reg;
    logic [RA_W-1:0]                clr_cnt_reg;
    logic                           out_valid_reg;
    logic                           out_valid_next;

    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [SAMPLE_WIDTH-1:0] y_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_reg;
    logic signed [PW-1:0]           prod_reg;
    logic signed [STW-1:0]          ring_q_reg;
    logic [PH_W-1:0]                ph_q_reg;
    logic [RA_W-1:0]                addr_reg;
    logic [RA_W-1:0]                base_reg;
    logic [SA_W-1:0]                k_reg;
    logic [SA_W-1:0]                nlast_reg;

    logic [SA_W-1:0]                nlast;
    logic [PH_W-1:0]                ph_inc;
    logic [RA_W-1:0]                ring_addr;
    logic signed [SAMPLE_WIDTH-1:0] mul_op;
    logic signed [PW:0]             psum;
    logic signed [PW:0]             rnd;
    logic signed [WW-1:0]           y_wide;
    logic signed [WW-1:0]           v_wide;
    logic signed [SAMPLE_WIDTH-1:0] y_sat;
    logic signed [STW-1:0]          v_sat;
    logic                           y_fits;
    logic                           v_fits;

    always_comb
    begin
        // A count of zero runs one stage; counts above the maximum run them all.
        if (stage_count == '0)
        begin
            nlast = '0;
        end
        else if (int'(stage_count) > MAX_STAGES)
        begin
            nlast = SA_W'(MAX_STAGES - 1);
        end
        else
        begin
            nlast = SA_W'(stage_count - 8'd1);
        end

        if (int'(ph_q_reg) == STAGE_DELAY - 1)
        begin
            ph_inc = '0;
        end
        else
        begin
            ph_inc = PH_W'(ph_q_reg + 1'b1);
        end

        ring_addr = RA_W'(base_reg + RA_W'(ph_q_reg));
        mul_op    = (ctrl.mul_src == adcd_pkg::MUL_Y) ? y_reg : x_reg;

        // Round half up, then floor shift back to the sample scale.
        psum = (PW+1)'(prod_reg) + ROUND_HALF;
        rnd  = psum >>> adcd_pkg::COEF_FRAC;

        y_wide = WW'(ring_q_reg) - WW'(rnd);
        y_fits = (&y_wide[WW-1:SAMPLE_WIDTH-1]) || !(|y_wide[WW-1:SAMPLE_WIDTH-1]);
        y_sat  = y_fits ? y_wide[SAMPLE_WIDTH-1:0]
                        : {y_wide[WW-1], {(SAMPLE_WIDTH-1){~y_wide[WW-1]}}};

        v_wide = WW'(x_reg) + WW'(rnd);
        v_fits = (&v_wide[WW-1:STW-1]) || !(|v_wide[WW-1:STW-1]);
        v_sat  = v_fits ? v_wide[STW-1:0] : {v_wide[WW-1], {(STW-1){~v_wide[WW-1]}}};

        out_valid_next = out_valid_reg;
        if (ctrl.out_ld)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        status.clr_busy   = clr_busy_reg;
        status.last_stage = (k_reg == nlast_reg);
        status.out_free   = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (clr_busy_reg)
            begin
                clr_cnt_reg <= RA_W'(clr_cnt_reg + 1'b1);
                if (int'(clr_cnt_reg) == RING_SIZE - 1)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
        end
    end

    // Ring and phase memories: zeroed by the sweep after reset.
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            ring_mem[clr_cnt_reg] <= '0;
        end
        else if (ctrl.ring_wr)
        begin
            ring_mem[addr_reg] <= v_sat;
        end
        if (ctrl.ring_rd)
        begin
            ring_q_reg <= ring_mem[ring_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            if (int'(clr_cnt_reg) < MAX_STAGES)
            begin
                phase_mem[clr_cnt_reg[SA_W-1:0]] <= '0;
            end
        end
        else if (ctrl.ph_wr)
        begin
            phase_mem[k_reg] <= ph_inc;
        end
        if (ctrl.ph_rd)
        begin
            ph_q_reg <= phase_mem[k_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_in)
        begin
            x_reg     <= sample_in;
            k_reg     <= '0;
            base_reg  <= '0;
            nlast_reg <= nlast;
        end
        else if (ctrl.adv)
        begin
            x_reg    <= y_reg;
            k_reg    <= SA_W'(k_reg + 1'b1);
            base_reg <= RA_W'(base_reg + RA_W'(STAGE_DELAY));
        end
        if (ctrl.mul_en)
        begin
            prod_reg <= PW'(coef) * PW'(mul_op);
        end
        if (ctrl.ring_rd)
        begin
            addr_reg <= ring_addr;
        end
        if (ctrl.y_ld)
        begin
            y_reg <= y_sat;
        end
        if (ctrl.out_ld)
        begin
            out_reg <= x_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = out_reg;

endmodule

FILE: rtl/core/allpass_cascade_disperser.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+--------------------------------
// input    | in_valid / in_ready  | sample_in
// output   | out_valid / out_ready| sample_out
// config   | cfg_we (no wait)     | cfg_addr, cfg_wdata
//
// For each active stage the microcode runs phase read, ring read, output sum,
// second multiply and state write-back, in that order, on one shared multiplier
// and one ring memory port.
// After reset a sweep zeroes the ring, all MAX_STAGES*STAGE_DELAY entries (256 by
// default), with in_ready low. A finished item waits in the output register
// while the next item is accepted; the sequencer stalls only if it finishes that
// next item before the first one is taken.
module allpass_cascade_disperser #(
    parameter int MAX_STAGES   = adcd_pkg::DEF_MAX_STAGES,
    parameter int STAGE_DELAY  = adcd_pkg::DEF_STAGE_DELAY,
    parameter int SAMPLE_WIDTH = adcd_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]       sample_in,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]       sample_out,
    input  logic                                 cfg_we,
    input  logic [adcd_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [adcd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    logic [adcd_pkg::COUNT_W-1:0]        stage_count_reg;
    logic signed [adcd_pkg::COEF_W-1:0]  feedback_coef_reg;
    adcd_pkg::ctrl_t                     ctrl;
    adcd_pkg::dp_status_t                status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_count_reg   <= adcd_pkg::COUNT_RESET;
            feedback_coef_reg <= adcd_pkg::COEF_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                adcd_pkg::REG_STAGE_COUNT:
                begin
                    stage_count_reg <= cfg_wdata[adcd_pkg::COUNT_W-1:0];
                end
                adcd_pkg::REG_FEEDBACK_COEF:
                begin
                    feedback_coef_reg <= cfg_wdata[adcd_pkg::COEF_W-1:0];
                end
                default:
                begin
                    stage_count_reg <= stage_count_reg;
                end
            endcase
        end
    end

    adcd_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .in_ready (in_ready),
        .ctrl     (ctrl)
    );

    adcd_datapath #(
        .MAX_STAGES   (MAX_STAGES),
        .STAGE_DELAY  (STAGE_DELAY),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .stage_count (stage_count_reg),
        .coef        (feedback_coef_reg),
        .sample_in   (sample_in),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .sample_out  (sample_out),
        .status      (status)
    );

endmodule

FILE: rtl/core/adcd_checker.sv
module adcd_checker #(
    parameter int SAMPLE_WIDTH = adcd_pkg::DEF_SAMPLE_WIDTH
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic [SAMPLE_WIDTH-1:0]       sample_in,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [SAMPLE_WIDTH-1:0]       sample_out
);

    // A result that is not taken stays in place.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out))
        else $error("sample_out changed while stalled");

    // Only one item is in work at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready stayed high after an item was accepted");

    // Even with a single stage, no result appears straight after its item is accepted.
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##1 !$rose(out_valid) ##1 !$rose(out_valid))
        else $error("result appeared too early");

    // The clearing sweep holds off input right after reset.
    a_clear_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !in_ready && !out_valid)
        else $error("block active before the ring was cleared");

    // A waiting input stays valid and holds its payload until it is taken.
    a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(sample_in))
        else $error("sample_in changed while waiting");

endmodule

bind allpass_cascade_disperser adcd_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_adcd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out)
);

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int MAXS    = adcd_pkg::DEF_MAX_STAGES;
    localparam int SDLY    = adcd_pkg::DEF_STAGE_DELAY;
    localparam int SW      = adcd_pkg::DEF_SAMPLE_WIDTH;
    localparam int STATE_W = SW + 4;
    localparam int CNT_W   = adcd_pkg::COUNT_W;
    localparam int CF_W    = adcd_pkg::COEF_W;
    localparam int CA_W    = adcd_pkg::CFG_ADDR_W;
    localparam int CD_W    = adcd_pkg::CFG_DATA_W;

    localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

    // Cycles for one item at the full stage count, plus a little margin.
    localparam int ITEM_CYCLES = 5 * MAXS + 60;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic signed [SW-1:0]   sample_in;
    logic                   out_valid;
    logic                   out_ready;
    logic signed [SW-1:0]   sample_out;
    logic                   cfg_we;
    logic [CA_W-1:0]        cfg_addr;
    logic [CD_W-1:0]        cfg_wdata;

    // Shadow copy of the block's registers and filter state.
    logic [CNT_W-1:0]          model_count;
    logic signed [CF_W-1:0]    model_coef;
    logic signed [STATE_W-1:0] ring_mem [MAXS*SDLY];
    int                        stage_ph [MAXS];

    logic signed [SW-1:0] expected_samples [$];
    int                   bad_count;
    int                   items_sent;
    bit                   idle_en;

    allpass_cascade_disperser u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #15000000;
        $display("[allpass_cascade_disperser] ERROR");
        $finish;
    end

    function automatic longint clamp(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // Q1.15 coefficient times a Q.F value, rounded half up back to Q.F.
    function automatic longint coef_scale(input longint a, input longint v);
        return (a * v + (longint'(1) <<< (adcd_pkg::COEF_FRAC - 1))) >>> adcd_pkg::COEF_FRAC;
    endfunction

    function automatic logic signed [SW-1:0] disperse_sample(input logic signed [SW-1:0] s);
        longint a;
        longint x;
        longint y;
        int     n;
        int     slot;
        a = longint'(model_coef);
        x = longint'(s);
        n = int'(model_count);
        if (n < 1)
            n = 1;
        if (n > MAXS)
            n = MAXS;
        for (int k = 0; k < n; k++)
        begin
            slot = k * SDLY + stage_ph[k];
            y = clamp(longint'(ring_mem[slot]) - coef_scale(a, x), SW);
            ring_mem[slot] = STATE_W'(clamp(x + coef_scale(a, y), STATE_W));
            stage_ph[k] = (stage_ph[k] + 1) % SDLY;
            x = y;
        end
        return x[SW-1:0];
    endfunction

    function automatic logic signed [SW-1:0] rand_sample();
        logic signed [SW-1:0] s;
        case ($urandom_range(0, 9))
            5: s = SMAX;
            6: s = SMIN;
            7: s = SW'(int'($urandom_range(0, 511)) - 256);
            8: s = ($urandom_range(0, 1) != 0) ? SMAX - SW'($urandom_range(0, 4095))
                                               : SMIN + SW'($urandom_range(0, 4095));
            default: s = SW'($urandom);
        endcase
        return s;
    endfunction

    // Called at a falling edge; drops cfg_we after the write, waits for another falling edge, then updates the model.
    task automatic write_reg(input logic [CA_W-1:0] addr,
                             input logic [CD_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        if (addr == adcd_pkg::REG_STAGE_COUNT)
            model_count = data[CNT_W-1:0];
        else if (addr == adcd_pkg::REG_FEEDBACK_COEF)
            model_coef = data[CF_W-1:0];
    endtask

    task automatic send_sample(input logic signed [SW-1:0] s);
        int gap;
        gap = idle_en ? $urandom_range(0, 8) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= s;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        expected_samples.push_back(disperse_sample(s));
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Result side: random stalls on out_ready, one compare per accepted item.
    initial
    begin
        logic signed [SW-1:0] want;
        int                   stall;
        out_ready = 1'b0;
        @(negedge clk);
        forever
        begin
            stall = idle_en ? $urandom_range(0, 8) : 0;
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            if (expected_samples.size() == 0)
            begin
                bad_count++;
                if (bad_count <= 10)
                    $display("%0t: unexpected item, sample_out %0d", $time, sample_out);
            end
            else
            begin
                want = expected_samples.pop_front();
                if (sample_out !== want)
                begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("%0t: sample_out expected %0d, got %0d",
                                 $time, want, sample_out);
                end
            end
            @(negedge clk);
        end
    end

    task automatic test_default_config();
        send_sample(SMAX);
        send_sample(SMIN);
        send_sample('0);
        send_sample(SW'(1));
        send_sample(SW'(-1));
        // Repeated full scale drives the stored state toward its limit.
        send_sample(SMAX);
        send_sample(SMAX);
    endtask

    task automatic test_stage_count_limits();
        wait_idle();
        write_reg(adcd_pkg::REG_STAGE_COUNT, CD_W'(0));
        send_sample(SMAX);
        send_sample(SMIN);
        wait_idle();
        write_reg(adcd_pkg::REG_STAGE_COUNT, CD_W'(MAXS));
        send_sample(SMIN);
        send_sample(SMAX);
        wait_idle();
        write_reg(adcd_pkg::REG_STAGE_COUNT, CD_W'(255));
        send_sample(SMAX);
        send_sample(SW'(-1));
    endtask

    task automatic test_coef_extremes();
        wait_idle();
        write_reg(adcd_pkg::REG_STAGE_COUNT, CD_W'(3));
        write_reg(adcd_pkg::REG_FEEDBACK_COEF, 16'h8000);
        send_sample(SMAX);
        send_sample(SMIN);
        send_sample(SMAX);
        wait_idle();
        write_reg(adcd_pkg::REG_FEEDBACK_COEF, 16'h7FFF);
        send_sample(SMIN);
        send_sample(SMAX);
        wait_idle();
        write_reg(adcd_pkg::REG_FEEDBACK_COEF, 16'h8001);
        send_sample(SMAX);
        send_sample(SMAX);
        wait_idle();
        write_reg(adcd_pkg::REG_FEEDBACK_COEF, 16'h0000);
        send_sample(SMIN);
    endtask

    task automatic test_random_traffic();
        logic [CD_W-1:0]       wdata;
        logic signed [SW-1:0]  amp;
        int                    pick;
        int                    shape;
        int                    phase_items;
        int                    target;
        target = items_sent + 400;
        while (items_sent < target)
        begin
            wait_idle();
            // Large stage counts are slow, so they get few items per phase.
            pick  = $urandom_range(0, 19);
            wdata = CD_W'($urandom);
            if (pick < 13)
                wdata[CNT_W-1:0] = CNT_W'($urandom_range(1, 8));
            else if (pick < 17)
                wdata[CNT_W-1:0] = CNT_W'($urandom_range(9, 40));
            else if (pick == 17)
                wdata[CNT_W-1:0] = '0;
            else
                wdata[CNT_W-1:0] = CNT_W'($urandom_range(MAXS, 255));
            if ($urandom_range(0, 3) != 0)
                write_reg(adcd_pkg::REG_STAGE_COUNT, wdata);
            case ($urandom_range(0, 7))
                0: wdata = 16'h8000;
                1: wdata = 16'h7FFF;
                2: wdata = 16'h8001;
                3: wdata = 16'h0000;
                default: wdata = CD_W'($urandom);
            endcase
            if ($urandom_range(0, 3) != 0)
                write_reg(adcd_pkg::REG_FEEDBACK_COEF, wdata);
            idle_en     = ($urandom_range(0, 3) != 0);
            phase_items = (model_count <= 40) ? $urandom_range(8, 40) : $urandom_range(2, 4);
            shape       = $urandom_range(0, 3);
            amp         = rand_sample();
            for (int i = 0; i < phase_items; i++)
            begin
                case (shape)
                    1: send_sample(amp);
                    2: send_sample((i % 2 != 0) ? amp : -amp);
                    default: send_sample(rand_sample());
                endcase
            end
        end
        idle_en = 1'b1;
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        sample_in  = '0;
        cfg_we     = 1'b0;
        cfg_addr   = '0;
        cfg_wdata  = '0;
        idle_en    = 1'b1;
        bad_count  = 0;
        items_sent = 0;
        model_count = adcd_pkg::COUNT_RESET;
        model_coef  = adcd_pkg::COEF_RESET;
        foreach (ring_mem[i])
            ring_mem[i] = '0;
        foreach (stage_ph[i])
            stage_ph[i] = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_default_config();
        test_stage_count_limits();
        test_coef_extremes();
        test_random_traffic();

        wait_idle();
        repeat (ITEM_CYCLES) @(negedge clk);
        if (bad_count == 0 && expected_samples.size() == 0)
            $display("[allpass_cascade_disperser] OK");
        else
            $display("[allpass_cascade_disperser] ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/adcd_pkg.sv
rtl/core/adcd_seq.sv
rtl/core/adcd_datapath.sv
rtl/core/allpass_cascade_disperser.sv
rtl/core/adcd_checker.sv
sim/testbench.sv
